// ----- sv/dmtc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmtc_pkg
// Shared types and constants of the direct-mapped cache tag check unit.
// ----------------------------------------------------------------------------
package dmtc_pkg;

    localparam int ADDR_W     = 32;
    localparam int IDX_W      = 14;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 4;
    localparam int SHAMT_W    = 5;

    localparam logic [CFG_W-1:0] MAX_OFFSET_BITS   = 4'd12;
    localparam logic [CFG_W-1:0] MAX_INDEX_BITS    = 4'd14;
    localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = 4'd4;
    localparam logic [CFG_W-1:0] INDEX_BITS_RESET  = 4'd8;

    // Stored line word: valid flag on top of the tag.
    localparam int LINE_W = TAG_W + 1;

    typedef enum logic [0:0] {
        OP_ACCESS = 1'b0,
        OP_INVAL  = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        CFG_OFFSET_BITS = 1'b0,
        CFG_INDEX_BITS  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_SLOT,
        ST_CHECK,
        ST_INVAL
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
    } split_t;

endpackage

// ----- sv/dmtc_ram.sv -----
// ----------------------------------------------------------------------------
// dmtc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dmtc_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16384
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/dmtc_decode.sv -----
// ----------------------------------------------------------------------------
// dmtc_decode
// Splits a byte address into line index and tag under the current geometry.
// ----------------------------------------------------------------------------
module dmtc_decode (
    input  logic [dmtc_pkg::CFG_W-1:0]  offset_bits,
    input  logic [dmtc_pkg::CFG_W-1:0]  index_bits,
    input  logic [dmtc_pkg::ADDR_W-1:0] address,
    output dmtc_pkg::split_t            split
);

    logic [dmtc_pkg::CFG_W-1:0]   ob;
    logic [dmtc_pkg::CFG_W-1:0]   ib;
    logic [dmtc_pkg::ADDR_W-1:0]  shifted;
    logic [dmtc_pkg::IDX_W-1:0]   idx_mask;
    logic [dmtc_pkg::SHAMT_W-1:0] tag_shamt;

    // Out-of-range geometry values behave as the largest legal value.
    assign ob = (offset_bits > dmtc_pkg::MAX_OFFSET_BITS) ? dmtc_pkg::MAX_OFFSET_BITS
                                                           : offset_bits;
    assign ib = (index_bits > dmtc_pkg::MAX_INDEX_BITS) ? dmtc_pkg::MAX_INDEX_BITS
                                                         : index_bits;

    assign shifted   = address >> ob;
    assign idx_mask  = ~({dmtc_pkg::IDX_W{1'b1}} << ib);
    assign tag_shamt = {1'b0, ob} + {1'b0, ib};

    assign split.idx = shifted[dmtc_pkg::IDX_W-1:0] & idx_mask;
    assign split.tag = address >> tag_shamt;

endmodule

// ----- sv/dmtc_slot.sv -----
// ----------------------------------------------------------------------------
// dmtc_slot
// Folds a line index onto the storage depth (index modulo LINES) using a
// registered reciprocal multiply followed by a multiply-back and subtract.
// ----------------------------------------------------------------------------
module dmtc_slot #(
    parameter int LINES = 16384
) (
    input  logic                                    aclk,
    input  logic [dmtc_pkg::IDX_W-1:0]              idx,
    output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] slot
);

    localparam int SLOT_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LINES_W  = $clog2(LINES + 1);
    // 28 fractional bits make the quotient exact for every 14-bit index.
    localparam int RECIP_SH = 2 * dmtc_pkg::IDX_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam longint RECIP = ((64'd1 << RECIP_SH) + LINES - 1) / LINES;
    localparam int PROD_W   = dmtc_pkg::IDX_W + RECIP_W;
    localparam int BACK_W   = dmtc_pkg::IDX_W + LINES_W;

    logic [PROD_W-1:0]          prod;
    logic [dmtc_pkg::IDX_W-1:0] quot_reg;
    logic [BACK_W-1:0]          back;
    logic [dmtc_pkg::IDX_W-1:0] rem;

    assign prod = PROD_W'(idx) * PROD_W'(RECIP_W'(RECIP));

    always_ff @(posedge aclk) begin
        quot_reg <= prod[RECIP_SH +: dmtc_pkg::IDX_W];
    end

    assign back = BACK_W'(quot_reg) * BACK_W'(LINES_W'(LINES));
    assign rem  = idx - back[dmtc_pkg::IDX_W-1:0];
    assign slot = SLOT_W'(rem);

endmodule

// ----- sv/direct_mapped_cache_tag_check_unit.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check_unit
// Tag store of a direct-mapped cache with saturating hit and miss counters.
// ----------------------------------------------------------------------------
// Each access transfer is looked up in a single tag RAM of LINES words, each
// holding a valid flag and a tag. An access passes from input transfer to a
// loaded result through these steps: accept and address split, quotient of the
// slot reduction, slot and RAM read, then compare with write-back on a miss.
// The next input is taken in the cycle after the result is loaded, and a
// result waits in the output register if the consumer stalls. The
// read-modify-write of one access finishes before the next one reads, so
// no forwarding is needed. After reset, and after every invalidate
// transfer, a clearing pass writes every RAM word invalid, one word per
// cycle; no input is taken meanwhile, while configuration
// writes are taken at any time. The invalidate result (all zero) is
// delivered at the start of that pass.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_check_unit #(
    parameter int LINES = 16384
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [dmtc_pkg::CFG_W-1:0]    cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [dmtc_pkg::ADDR_W-1:0]   s_address,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [dmtc_pkg::IDX_W-1:0]    m_line_index,
    output logic [dmtc_pkg::CNT_W-1:0]    m_hit_total,
    output logic [dmtc_pkg::CNT_W-1:0]    m_miss_total
);

    localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;

    dmtc_pkg::state_t state_reg, state_next;

    logic [dmtc_pkg::CFG_W-1:0]  offset_bits_reg;
    logic [dmtc_pkg::CFG_W-1:0]  index_bits_reg;

    logic [dmtc_pkg::IDX_W-1:0]  idx_reg;
    logic [dmtc_pkg::TAG_W-1:0]  tag_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic [SLOT_W-1:0]           clr_cnt_reg;
    logic [dmtc_pkg::CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [dmtc_pkg::CNT_W-1:0]  miss_cnt_reg, miss_cnt_next;

    logic                        m_valid_reg;
    logic                        m_hit_reg;
    logic [dmtc_pkg::IDX_W-1:0]  m_line_index_reg;
    logic [dmtc_pkg::CNT_W-1:0]  m_hit_total_reg;
    logic [dmtc_pkg::CNT_W-1:0]  m_miss_total_reg;

    dmtc_pkg::split_t            split;
    logic [SLOT_W-1:0]           slot;

    logic                        ram_wr_en;
    logic [SLOT_W-1:0]           ram_wr_addr;
    logic [dmtc_pkg::LINE_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [dmtc_pkg::LINE_W-1:0] ram_rd_data;

    logic                        in_xfer;
    logic                        out_free;
    logic                        clr_last;
    logic                        lookup_hit;
    logic                        load_access;
    logic                        load_inval;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign clr_last = (clr_cnt_reg == SLOT_W'(LINES - 1));

    assign lookup_hit = ram_rd_data[dmtc_pkg::TAG_W] &&
                        (ram_rd_data[dmtc_pkg::TAG_W-1:0] == tag_reg);

    assign hit_cnt_next  = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
    assign miss_cnt_next = (miss_cnt_reg == '1) ? miss_cnt_reg : miss_cnt_reg + 1'b1;

    dmtc_decode u_decode (
        .offset_bits (offset_bits_reg),
        .index_bits  (index_bits_reg),
        .address     (s_address),
        .split       (split)
    );

    dmtc_slot #(
        .LINES (LINES)
    ) u_slot (
        .aclk (aclk),
        .idx  (idx_reg),
        .slot (slot)
    );

    dmtc_ram #(
        .WIDTH (dmtc_pkg::LINE_W),
        .DEPTH (LINES)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dmtc_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = dmtc_pkg::ST_IDLE;
                end
            end
            dmtc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_opcode == dmtc_pkg::OP_INVAL) begin
                        state_next = dmtc_pkg::ST_INVAL;
                    end else begin
                        state_next = dmtc_pkg::ST_QUOT;
                    end
                end
            end
            dmtc_pkg::ST_QUOT: begin
                state_next = dmtc_pkg::ST_SLOT;
            end
            dmtc_pkg::ST_SLOT: begin
                state_next = dmtc_pkg::ST_CHECK;
            end
            dmtc_pkg::ST_CHECK: begin
                if (out_free) begin
                    state_next = dmtc_pkg::ST_IDLE;
                end
            end
            dmtc_pkg::ST_INVAL: begin
                if (out_free) begin
                    state_next = dmtc_pkg::ST_CLEAR;
                end
            end
            default: begin
                state_next = dmtc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, RAM port controls, result loads.
    always_comb begin
        s_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = {1'b1, tag_reg};
        ram_rd_en   = 1'b0;
        load_access = 1'b0;
        load_inval  = 1'b0;
        unique case (state_reg)
            dmtc_pkg::ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = '0;
            end
            dmtc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            dmtc_pkg::ST_QUOT: begin
            end
            dmtc_pkg::ST_SLOT: begin
                ram_rd_en = 1'b1;
            end
            dmtc_pkg::ST_CHECK: begin
                load_access = out_free;
                ram_wr_en   = out_free && !lookup_hit;
            end
            dmtc_pkg::ST_INVAL: begin
                load_inval = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= dmtc_pkg::ST_CLEAR;
            offset_bits_reg <= dmtc_pkg::OFFSET_BITS_RESET;
            index_bits_reg  <= dmtc_pkg::INDEX_BITS_RESET;
            clr_cnt_reg     <= '0;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (dmtc_pkg::cfg_reg_t'(cfg_index))
                    dmtc_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_wr_data;
                    dmtc_pkg::CFG_INDEX_BITS:  index_bits_reg  <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end

            if (state_reg == dmtc_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            end

            if (load_access) begin
                if (lookup_hit) begin
                    hit_cnt_reg <= hit_cnt_next;
                end else begin
                    miss_cnt_reg <= miss_cnt_next;
                end
            end else if (load_inval) begin
                hit_cnt_reg  <= '0;
                miss_cnt_reg <= '0;
            end

            if (load_access || load_inval) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            idx_reg <= split.idx;
            tag_reg <= split.tag;
        end
        if (state_reg == dmtc_pkg::ST_SLOT) begin
            slot_reg <= slot;
        end
        if (load_access) begin
            m_hit_reg        <= lookup_hit;
            m_line_index_reg <= idx_reg;
            m_hit_total_reg  <= lookup_hit ? hit_cnt_next : hit_cnt_reg;
            m_miss_total_reg <= lookup_hit ? miss_cnt_reg : miss_cnt_next;
        end else if (load_inval) begin
            m_hit_reg        <= 1'b0;
            m_line_index_reg <= '0;
            m_hit_total_reg  <= '0;
            m_miss_total_reg <= '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_line_index = m_line_index_reg;
    assign m_hit_total  = m_hit_total_reg;
    assign m_miss_total = m_miss_total_reg;

endmodule
